// File: sv/spom_pkg.sv
// ----------------------------------------------------------------------------
// spom_pkg: shared types and constants of the spiral-order matrix scan
// Field widths, configuration register indexes, scan direction and the
// cursor record passed between the core and the spiral step unit.
// ----------------------------------------------------------------------------
package spom_pkg;

  // Payload field widths
  localparam int ValW      = 32;
  localparam int RowW      = 3;
  localparam int ColW      = 3;
  localparam int CfgW      = 4;
  localparam int CfgIdxW   = 1;
  localparam int TdataInW  = 32;
  localparam int TdataOutW = 40;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRows = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCols = 1'b1;

  typedef enum logic [1:0] {
    DirRight,
    DirDown,
    DirLeft,
    DirUp
  } dir_e;

  typedef enum logic {
    StLoad,
    StScan
  } state_e;

  // Spiral cursor: current position, heading and the bounds of the open ring
  typedef struct packed {
    dir_e            dir;
    logic [RowW-1:0] row;
    logic [RowW-1:0] top;
    logic [RowW-1:0] bot;
    logic [ColW-1:0] col;
    logic [ColW-1:0] left;
    logic [ColW-1:0] right;
  } cursor_t;

endpackage

// File: sv/spom_ram.sv
// ----------------------------------------------------------------------------
// spom_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module spom_ram #(
  parameter int  Width = 32,
  parameter int  Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/spom_step.sv
// ----------------------------------------------------------------------------
// spom_step: spiral step unit
// Moves the cursor one element along the clockwise spiral and flags the
// final element. Used once per emitted element by the core's sequencer.
// ----------------------------------------------------------------------------
module spom_step (
  input  spom_pkg::cursor_t cur_i,
  output spom_pkg::cursor_t nxt_o,
  output logic              done_o
);
  import spom_pkg::*;

  // Advance along the current edge, or turn and shrink the ring at a corner
  always_comb begin
    nxt_o  = cur_i;
    done_o = 1'b0;
    unique case (cur_i.dir)
      DirRight: begin
        if (cur_i.col != cur_i.right) begin
          nxt_o.col = cur_i.col + 1'b1;
        end else begin
          done_o    = (cur_i.top == cur_i.bot);
          nxt_o.top = cur_i.top + 1'b1;
          nxt_o.row = cur_i.row + 1'b1;
          nxt_o.dir = DirDown;
        end
      end
      DirDown: begin
        if (cur_i.row != cur_i.bot) begin
          nxt_o.row = cur_i.row + 1'b1;
        end else begin
          done_o      = (cur_i.left == cur_i.right);
          nxt_o.right = cur_i.right - 1'b1;
          nxt_o.col   = cur_i.col - 1'b1;
          nxt_o.dir   = DirLeft;
        end
      end
      DirLeft: begin
        if (cur_i.col != cur_i.left) begin
          nxt_o.col = cur_i.col - 1'b1;
        end else begin
          done_o    = (cur_i.top == cur_i.bot);
          nxt_o.bot = cur_i.bot - 1'b1;
          nxt_o.row = cur_i.row - 1'b1;
          nxt_o.dir = DirUp;
        end
      end
      DirUp: begin
        if (cur_i.row != cur_i.top) begin
          nxt_o.row = cur_i.row - 1'b1;
        end else begin
          done_o     = (cur_i.left == cur_i.right);
          nxt_o.left = cur_i.left + 1'b1;
          nxt_o.col  = cur_i.col + 1'b1;
          nxt_o.dir  = DirRight;
        end
      end
      default: begin
        nxt_o  = cur_i;
        done_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/spiral_order_matrix_scan_core.sv
// Load: one element per cycle, s_axis_tready high while loading.
// Scan: the step unit and the RAM read port yield one result per cycle
//   unless the output stalls; the first result passes the RAM read and output
//   registers after the completing load transaction, and input stays stalled
//   until the read of the final element is issued.
// Reset clears control state and sets an 8 x 8 size; RAM contents stay as is.
// ----------------------------------------------------------------------------
// spiral_order_matrix_scan_core: spiral-order matrix scan
// Stores a row-major matrix, then streams it out in clockwise spiral order
// with row, column and a last marker.
// ----------------------------------------------------------------------------
module spiral_order_matrix_scan_core #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [spom_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [spom_pkg::CfgW-1:0]        cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [spom_pkg::TdataInW-1:0]    s_axis_tdata,  // [31:0] element_value
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] out_value, [34:32] out_row, [37:35] out_col, [39:38] zero
  output logic [spom_pkg::TdataOutW-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast   // last_of_scan
);
  import spom_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PadW  = TdataOutW - ValW - RowW - ColW;

  state_e state_q, state_d;

  logic [CfgW-1:0] cfg_rows_q, cfg_cols_q;
  logic [CfgW-1:0] rows_eff, cols_eff;
  logic [RowW-1:0] last_row;
  logic [ColW-1:0] last_col;

  logic [RowW-1:0] ld_row_q;
  logic [ColW-1:0] ld_col_q;
  logic            ld_last;
  logic            in_acc;

  cursor_t cur_q, cur_nxt;
  logic    step_done;

  logic             issue;
  logic             out_free;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [ValW-1:0]  rd_data;

  logic            rd_pend_q;
  logic [RowW-1:0] rd_row_q;
  logic [ColW-1:0] rd_col_q;
  logic            rd_last_q;

  logic                   out_valid_q;
  logic signed [ValW-1:0] out_value_q;
  logic [RowW-1:0]        out_row_q;
  logic [ColW-1:0]        out_col_q;
  logic                   out_last_q;

  // Clamp configured sizes into 1..MAX
  always_comb begin
    if (cfg_rows_q == '0) begin
      rows_eff = CfgW'(1);
    end else if (cfg_rows_q > CfgW'(MAX_ROWS)) begin
      rows_eff = CfgW'(MAX_ROWS);
    end else begin
      rows_eff = cfg_rows_q;
    end
    if (cfg_cols_q == '0) begin
      cols_eff = CfgW'(1);
    end else if (cfg_cols_q > CfgW'(MAX_COLS)) begin
      cols_eff = CfgW'(MAX_COLS);
    end else begin
      cols_eff = cfg_cols_q;
    end
  end

  assign last_row = RowW'(rows_eff - 1'b1);
  assign last_col = ColW'(cols_eff - 1'b1);

  // Handshake and sequencing terms
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign ld_last  = (ld_row_q == last_row) && (ld_col_q == last_col);
  assign out_free = !out_valid_q || m_axis_tready;
  assign issue    = (state_q == StScan) && (!rd_pend_q || out_free);

  assign wr_addr = AddrW'(int'(ld_row_q) * MAX_COLS + int'(ld_col_q));
  assign rd_addr = AddrW'(int'(cur_q.row) * MAX_COLS + int'(cur_q.col));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc && ld_last) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (issue && step_done) begin
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    unique case (state_q)
      StLoad:  s_axis_tready = 1'b1;
      StScan:  s_axis_tready = 1'b0;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q <= CfgW'(8);
      cfg_cols_q <= CfgW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRows: cfg_rows_q <= cfg_data_i;
        CfgCols: cfg_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Load position: restart on a size write, wrap after the final element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
    end else if (cfg_we_i) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
    end else if (in_acc) begin
      if (ld_last) begin
        ld_row_q <= '0;
        ld_col_q <= '0;
      end else if (ld_col_q == last_col) begin
        ld_col_q <= '0;
        ld_row_q <= ld_row_q + 1'b1;
      end else begin
        ld_col_q <= ld_col_q + 1'b1;
      end
    end
  end

  // Spiral cursor: start at the top-left on the completing load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (in_acc && ld_last) begin
      cur_q.dir   <= DirRight;
      cur_q.row   <= '0;
      cur_q.top   <= '0;
      cur_q.bot   <= last_row;
      cur_q.col   <= '0;
      cur_q.left  <= '0;
      cur_q.right <= last_col;
    end else if (issue) begin
      cur_q <= cur_nxt;
    end
  end

  spom_step u_step (
    .cur_i  (cur_q),
    .nxt_o  (cur_nxt),
    .done_o (step_done)
  );

  spom_ram #(
    .Width (ValW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wr_addr),
    .wdata_i (s_axis_tdata[ValW-1:0]),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Read in flight: hold its position until the output register frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= issue | (rd_pend_q & !out_free);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_row_q  <= cur_q.row;
      rd_col_q  <= cur_q.col;
      rd_last_q <= step_done;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= rd_pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && rd_pend_q) begin
      out_value_q <= rd_data;
      out_row_q   <= rd_row_q;
      out_col_q   <= rd_col_q;
      out_last_q  <= rd_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {PadW'(0), out_col_q, out_row_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: sv/spom_checker.sv
// ----------------------------------------------------------------------------
// spom_checker: port-level checks of the spiral-order matrix scan
// Watches the top-level ports and flags misbehaviour over time.
// ----------------------------------------------------------------------------
module spom_checker #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [spom_pkg::TdataOutW-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);
  import spom_pkg::*;

  // No result is offered in the cycle after reset is seen
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // Once loading stops, a result must follow on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $fell(s_axis_tready) |-> ##[0:2] m_axis_tvalid)
    else $error("scan started without a result");

  // Emitted coordinates stay inside MAX_ROWS x MAX_COLS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid |-> (m_axis_tdata[ValW+RowW-1:ValW] < MAX_ROWS) &&
                                     (m_axis_tdata[ValW+RowW+ColW-1:ValW+RowW] < MAX_COLS))
    else $error("result position outside the matrix");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid && !m_axis_tready |=>
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind spiral_order_matrix_scan_core spom_checker #(
  .MAX_ROWS (MAX_ROWS),
  .MAX_COLS (MAX_COLS)
) u_spom_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the spiral-order matrix scan core
// Loads matrices over the input stream, predicts each spiral scan in the
// bench and checks every output transaction against it. A short table of
// directed steps comes first, then random sizes and contents with bursty
// input, a stalling output side and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import spom_pkg::*;

  localparam int MaxRows   = 8;
  localparam int MaxCols   = 8;
  localparam int RandItems = 250;
  localparam int HoldOff   = 500;
  localparam int NumSteps  = 27;

  // One emitted element: value, position and end-of-scan marker
  typedef struct packed {
    logic [ValW-1:0] value;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } scan_res_t;

  typedef enum logic {
    StepCfg,
    StepElem
  } step_kind_e;

  // One row of the directed table; want_res is used only where typed is set
  typedef struct {
    step_kind_e          kind;
    logic [CfgIdxW-1:0]  idx;
    logic [ValW-1:0]     data;
    bit                  typed;
    scan_res_t           want_res;
  } stim_step_t;

  localparam scan_res_t NoRes = '0;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TdataInW-1:0]  s_axis_tdata;   // [31:0] element_value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TdataOutW-1:0] m_axis_tdata;   // [31:0] value, [34:32] row, [37:35] col
  logic                 m_axis_tlast;   // last_of_scan

  // Bench copy of the block state
  logic [ValW-1:0] elem_store [MaxRows*MaxCols];
  logic [CfgW-1:0] rows_cfg;
  logic [CfgW-1:0] cols_cfg;
  int              load_cnt;

  scan_res_t  pending_scan_q [$];
  scan_res_t  expected_scan_q [$];
  stim_step_t directed_tab [NumSteps];

  int fail_cnt;
  int burst_left;
  int holds_asked;
  int holds_done;

  spiral_order_matrix_scan_core #(
    .MAX_ROWS (MaxRows),
    .MAX_COLS (MaxCols)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Size register as the block uses it: zero reads as one, saturate at max
  function automatic int eff_size(input logic [CfgW-1:0] v, input int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void emit_at(input int r, input int c);
    pending_scan_q.push_back('{value: elem_store[r*MaxCols + c], row: RowW'(r),
                               col: ColW'(c), last: 1'b0});
  endfunction

  // Walk the rings clockwise from the top-left corner, moving inward
  function automatic void emit_spiral(input int rows, input int cols);
    int top, left, h, w, i;
    top  = 0;
    left = 0;
    h    = rows;
    w    = cols;
    while (w > 0 && h > 0) begin
      // a ring of one column or one row is emitted once
      if (w == 1) begin
        for (i = top; i < top + h; i++) emit_at(i, left);
        break;
      end
      if (h == 1) begin
        for (i = left; i < left + w; i++) emit_at(top, i);
        break;
      end
      for (i = left; i < left + w; i++) emit_at(top, i);
      for (i = top + 1; i < top + h; i++) emit_at(i, left + w - 1);
      for (i = left + w - 2; i >= left; i--) emit_at(top + h - 1, i);
      for (i = top + h - 2; i > top; i--) emit_at(i, left);
      top++;
      left++;
      w -= 2;
      h -= 2;
    end
    pending_scan_q[pending_scan_q.size() - 1].last = 1'b1;
  endfunction

  // Store one element in row-major order; the completing element yields the scan
  function automatic void absorb_element(input logic [ValW-1:0] v);
    int rows, cols, total, r, c;
    rows  = eff_size(rows_cfg, MaxRows);
    cols  = eff_size(cols_cfg, MaxCols);
    total = rows * cols;
    if (load_cnt >= total) load_cnt = 0;
    r = load_cnt / cols;
    c = load_cnt % cols;
    elem_store[r*MaxCols + c] = v;
    load_cnt = (load_cnt + 1) & 127;
    if (load_cnt >= total) begin
      load_cnt = 0;
      emit_spiral(rows, cols);
    end
  endfunction

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly legal sizes, now and then zero or above the maximum
  function automatic logic [CfgW-1:0] pick_size();
    if ($urandom_range(0, 9) != 0) return CfgW'($urandom_range(1, 8));
    return CfgW'($urandom_range(0, 15));
  endfunction

  // Write one register once the block has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_scan_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRows) rows_cfg = val;
    else cols_cfg = val;
    // a write drops any partial matrix
    load_cnt = 0;
  endtask

  // Offer one element in bursts with random gaps, then predict its results
  task automatic send_elem(input logic [ValW-1:0] v, input bit typed,
                           input scan_res_t typed_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_element(v);
    if (typed) begin
      expected_scan_q.push_back(typed_res);
    end else begin
      foreach (pending_scan_q[k]) expected_scan_q.push_back(pending_scan_q[k]);
    end
    pending_scan_q.delete();
  endtask

  // Output side: stall on a pattern of its own, hold off hard on request
  initial begin : scan_receiver
    int       rx_mode, rx_left, hold_left;
    logic [7:0] rx_pat;
    m_axis_tready = 1'b0;
    rx_mode   = 0;
    rx_left   = 0;
    hold_left = 0;
    rx_pat    = 8'b1100_1010;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        hold_left  = HoldOff;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1) != 0;
          2: m_axis_tready <= $urandom_range(0, 3) == 0;
          default: begin
            rx_pat = {rx_pat[6:0], rx_pat[7]};
            m_axis_tready <= rx_pat[0];
          end
        endcase
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : scan_checker
    scan_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{value: m_axis_tdata[31:0], row: m_axis_tdata[34:32],
              col: m_axis_tdata[37:35], last: m_axis_tlast};
      if (expected_scan_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("%0t: unexpected result value=%h row=%0d col=%0d last=%0b",
                   $realtime, got.value, got.row, got.col, got.last);
        fail_cnt++;
      end else begin
        want = expected_scan_q.pop_front();
        if (got.value !== want.value || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          if (fail_cnt < 10)
            $display("%0t: mismatch exp value=%h row=%0d col=%0d last=%0b, got value=%h row=%0d col=%0d last=%0b",
                     $realtime, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int rand_items, nmat, part, total, m, sel;
    bit first_phase, need_write;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgRows;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    fail_cnt      = 0;
    burst_left    = 0;
    holds_asked   = 0;
    holds_done    = 0;
    rows_cfg      = 4'd8;
    cols_cfg      = 4'd8;
    load_cnt      = 0;
    foreach (elem_store[k]) elem_store[k] = '0;

    // Directed steps: partial load at reset size, 1x1 extremes, one row,
    // one column, then a 2x2 ring
    directed_tab = '{
      '{StepElem, CfgRows, 32'h1234_5678, 1'b0, NoRes},
      '{StepCfg,  CfgRows, 32'd0,         1'b0, NoRes},
      '{StepCfg,  CfgCols, 32'd0,         1'b0, NoRes},
      '{StepElem, CfgRows, 32'h8000_0000, 1'b1, '{32'h8000_0000, 3'd0, 3'd0, 1'b1}},
      '{StepElem, CfgRows, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 3'd0, 3'd0, 1'b1}},
      '{StepElem, CfgRows, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1}},
      '{StepElem, CfgRows, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 3'd0, 1'b1}},
      '{StepCfg,  CfgCols, 32'd15,        1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0000_0001, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0000_0002, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h4000_0000, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'hC000_0000, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h5555_5555, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'hAAAA_AAAA, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h7FFF_FFFE, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h8000_0001, 1'b0, NoRes},
      '{StepCfg,  CfgRows, 32'd3,         1'b0, NoRes},
      '{StepCfg,  CfgCols, 32'd1,         1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0F0F_0F0F, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'hF0F0_F0F0, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0000_FFFF, 1'b0, NoRes},
      '{StepCfg,  CfgRows, 32'd2,         1'b0, NoRes},
      '{StepCfg,  CfgCols, 32'd2,         1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0001_0001, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0002_0002, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0003_0003, 1'b0, NoRes},
      '{StepElem, CfgRows, 32'h0004_0004, 1'b0, NoRes}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tab[k]) begin
      if (directed_tab[k].kind == StepCfg)
        write_reg(directed_tab[k].idx, directed_tab[k].data[CfgW-1:0]);
      else
        send_elem(directed_tab[k].data, directed_tab[k].typed, directed_tab[k].want_res);
    end

    // Random phases: first two full 8x8 matrices against a long output hold-off,
    // then random sizes, repeated sizes and the odd abandoned load
    rand_items  = 0;
    need_write  = 1'b0;
    first_phase = 1'b1;
    while (rand_items < RandItems) begin
      if (first_phase) begin
        write_reg(CfgRows, 4'd8);
        write_reg(CfgCols, 4'd8);
        holds_asked++;
        nmat = 2;
      end else begin
        sel = $urandom_range(0, 9);
        if (need_write || sel < 6) begin
          write_reg(CfgRows, pick_size());
          write_reg(CfgCols, pick_size());
        end else if (sel < 8) begin
          write_reg(($urandom_range(0, 1) != 0) ? CfgCols : CfgRows, pick_size());
        end
        nmat = $urandom_range(1, 2);
      end
      need_write = 1'b0;
      total = eff_size(rows_cfg, MaxRows) * eff_size(cols_cfg, MaxCols);
      for (m = 0; m < nmat && !need_write; m++) begin
        part = total;
        // abandon a load part way; the next write drops it
        if (!first_phase && total > 1 && $urandom_range(0, 7) == 0) begin
          part       = $urandom_range(1, total - 1);
          need_write = 1'b1;
        end
        for (int k = 0; k < part; k++) begin
          send_elem(rand_value(), 1'b0, NoRes);
          rand_items++;
        end
      end
      first_phase = 1'b0;
    end

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    while (expected_scan_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_scan_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
